>>> sv/hall_pair_nearest_angle_defines.svh
// Assertion macros used by the checker of the Hall pair angle lookup.
// Depends on nothing; include by bare file name.
`ifndef HALL_PAIR_NEAREST_ANGLE_DEFINES_SVH
`define HALL_PAIR_NEAREST_ANGLE_DEFINES_SVH

// Implication within the same cycle, cleared during reset.
`define HPNA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle, cleared during reset.
`define HPNA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/hpna_pkg.sv
// Package for the Hall pair nearest angle lookup: port widths, codes,
// divide-by-seven constants and the sequencer state type. No dependencies.
package hpna_pkg;

	localparam int IN_DATA_W       = 80;
	localparam int IN_USER_W       = 2;
	localparam int OUT_DATA_W      = 24;
	localparam int CFG_W           = 9;
	localparam int FIELD_READING_W = 12;
	localparam int ENTRY_IDX_W     = 8;
	localparam int ANGLE_W         = 11;

	localparam logic [CFG_W-1:0] ENTRIES_RESET = 9'd256;

	localparam logic ACTION_WRITE = 1'b0;
	localparam logic ACTION_QUERY = 1'b1;
	localparam logic SIDE_LEFT    = 1'b0;
	localparam logic SIDE_RIGHT   = 1'b1;

	// floor(x / 7) == (x * DIV7_MULT) >> DIV7_SHIFT for every x below 2**DIV7_IN_W
	localparam int DIV7_IN_W   = 18;
	localparam int DIV7_MULT_W = 19;
	localparam int DIV7_SHIFT  = 21;
	localparam logic [DIV7_MULT_W-1:0] DIV7_MULT = 19'd299594;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

endpackage

>>> sv/hpna_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hpna_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/hall_pair_nearest_angle.sv
// Hall pair nearest angle lookup, top level.
// Depends on hpna_pkg and hpna_ram.
//
// Usage:
//   s_* channel takes items. s_tuser[0] is the action: a write transaction
//   loads one calibration entry (no result), a query transaction scans the
//   table for the entry nearest to the live Hall pair of the chosen motor.
//   m_* channel returns one result per query: angle and nearest entry index.
//   cfg_* channel writes entries_in_use (always ready; write only when idle).
// Timing:
//   After a write, s_tready stays high.
//   A query holds s_tready low while the shared distance unit walks the table
//   one entry per cycle from the RAM read port: N = entries_in_use (0 taken
//   as 1, saturated at TABLE_DEPTH). The sequencer then drains the pipeline,
//   scales the best index by 40/7 and loads the result; s_tready rises again once it is loaded.
// Reset:
//   arst_n clears the sequencer, the pipeline valids, the output valid and
//   sets entries_in_use to 256. Table contents are undefined until written.
// Back-pressure:
//   The result waits in the output register; a new item is accepted while it
//   waits, but a following query holds its own result until the slot frees.
module hall_pair_nearest_angle #(
	parameter int TABLE_DEPTH  = 256,
	parameter int READING_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// entry_index[7:0], left_first[19:8], left_second[31:20], right_first[43:32],
	// right_second[55:44], hall_first[67:56], hall_second[79:68]
	input  logic [hpna_pkg::IN_DATA_W-1:0]  s_tdata,
	// action[0], motor_side[1]
	input  logic [hpna_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// angle[10:0], nearest_entry[18:11], zero[23:19]
	output logic [hpna_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hpna_pkg::CFG_W-1:0]      cfg_data
);

	import hpna_pkg::*;

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int RB    = (READING_BITS < FIELD_READING_W) ? READING_BITS : FIELD_READING_W;
	localparam int EW    = 4 * RB;
	localparam int CW    = ($clog2(TABLE_DEPTH + 1) > CFG_W) ? $clog2(TABLE_DEPTH + 1) : CFG_W;
	localparam int IW    = (AW > ENTRY_IDX_W) ? AW : ENTRY_IDX_W;
	localparam int SQW   = 2 * RB;
	localparam int DW    = SQW + 1;
	localparam int PW    = DIV7_IN_W + DIV7_MULT_W;
	localparam int PAD_W = OUT_DATA_W - ANGLE_W - ENTRY_IDX_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0] entries_q;
	logic             side_q;
	logic [RB-1:0]    h0_q, h1_q;
	logic [AW-1:0]    addr_q, last_q;

	logic             vld_s1, last_s1;
	logic [AW-1:0]    idx_s1;
	logic             vld_s2, last_s2;
	logic [AW-1:0]    idx_s2;
	logic [SQW-1:0]   sq_a_s2, sq_b_s2;

	logic [AW-1:0]    best_q;
	logic [DW-1:0]    best_dist_q;
	logic [PW-1:0]    prod_q;

	logic                  out_vld_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic          in_acc, is_query, ram_we, issue, out_load, take;
	logic [CW-1:0] cnt_raw, cnt_sat;
	logic [AW-1:0] last_idx;
	logic [EW-1:0] wdata, rdata;
	logic [RB-1:0] ea, eb, da, db;
	logic [SQW-1:0] sq_a, sq_b;
	logic [DW-1:0] dist_sum;
	logic [DIV7_IN_W-1:0] x40;
	logic [PW-1:0] prod;
	logic [IW-1:0] best_ext;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign is_query  = (s_tuser[0] == ACTION_QUERY);
	assign issue     = (state_q == ST_SCAN);
	assign out_load  = (state_q == ST_FINISH) && (!out_vld_q || m_tready);

	// Scan length: zero taken as one, saturate at the table depth
	always_comb begin
		cnt_raw = CW'(entries_q);
		cnt_sat = cnt_raw;
		if (cnt_raw == '0) begin
			cnt_sat = CW'(1);
		end else if (cnt_raw > CW'(TABLE_DEPTH)) begin
			cnt_sat = CW'(TABLE_DEPTH);
		end
		last_idx = AW'(cnt_sat - CW'(1));
	end

	// Drop writes aimed beyond the table
	assign ram_we = in_acc && !is_query && (CW'(s_tdata[7:0]) < CW'(TABLE_DEPTH));
	assign wdata  = {s_tdata[44 +: RB], s_tdata[32 +: RB], s_tdata[20 +: RB], s_tdata[8 +: RB]};

	hpna_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(s_tdata[7:0])),
		.wdata (wdata),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// Distance unit, first half: column select, absolute differences, squares
	always_comb begin
		ea   = (side_q == SIDE_RIGHT) ? rdata[2*RB +: RB] : rdata[0 +: RB];
		eb   = (side_q == SIDE_RIGHT) ? rdata[3*RB +: RB] : rdata[RB +: RB];
		da   = (ea >= h0_q) ? (ea - h0_q) : (h0_q - ea);
		db   = (eb >= h1_q) ? (eb - h1_q) : (h1_q - eb);
		sq_a = SQW'(da) * SQW'(da);
		sq_b = SQW'(db) * SQW'(db);
	end

	// Second half: sum and keep the first minimum
	assign dist_sum = DW'(sq_a_s2) + DW'(sq_b_s2);
	assign take     = vld_s2 && ((idx_s2 == '0) || (dist_sum < best_dist_q));

	assign x40  = (DIV7_IN_W'(best_q) << 5) + (DIV7_IN_W'(best_q) << 3);
	assign prod = PW'(x40) * PW'(DIV7_MULT);
	assign best_ext = IW'(best_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && is_query) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (addr_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (vld_s2 && last_s2) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			entries_q <= ENTRIES_RESET;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				entries_q <= cfg_data;
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && is_query) begin
			side_q <= s_tuser[1];
			h0_q   <= s_tdata[56 +: RB];
			h1_q   <= s_tdata[68 +: RB];
			last_q <= last_idx;
			addr_q <= '0;
		end else if (issue) begin
			addr_q <= addr_q + AW'(1);
		end
		idx_s1  <= addr_q;
		last_s1 <= (addr_q == last_q);
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		sq_a_s2 <= sq_a;
		sq_b_s2 <= sq_b;
		if (take) begin
			best_q      <= idx_s2;
			best_dist_q <= dist_sum;
		end
		if (state_q == ST_DIVIDE) begin
			prod_q <= prod;
		end
		if (out_load) begin
			out_data_q <= {{PAD_W{1'b0}}, best_ext[ENTRY_IDX_W-1:0],
				prod_q[DIV7_SHIFT +: ANGLE_W]};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

>>> sv/hpna_checker.sv
// Port-level checker for the Hall pair nearest angle lookup, bound to the top.
// Depends on hall_pair_nearest_angle_defines.svh.
`include "hall_pair_nearest_angle_defines.svh"

module hpna_checker #(
	parameter int TABLE_DEPTH = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	localparam logic SMALL_TABLE = (TABLE_DEPTH <= 256);

	logic        query_txn, write_txn, out_stall;
	logic [13:0] angle_x7, entry_x40;

	assign query_txn = s_tvalid && s_tready && s_tuser[0];
	assign write_txn = s_tvalid && s_tready && !s_tuser[0];
	assign out_stall = m_tvalid && !m_tready;
	assign angle_x7  = 14'(m_tdata[10:0]) * 14'd7;
	assign entry_x40 = 14'(m_tdata[18:11]) * 14'd40;

	`HPNA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid,
		"result transaction withdrawn while stalled")
	`HPNA_ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(m_tdata),
		"result payload changed while stalled")
	`HPNA_ASSERT_NEXT(a_query_busy, clk, arst_n, query_txn, !s_tready,
		"input still ready after a query transaction")
	`HPNA_ASSERT_NEXT(a_write_ready, clk, arst_n, write_txn, s_tready,
		"input not ready after a write transaction")
	`HPNA_ASSERT_SAME(a_angle_match, clk, arst_n, m_tvalid && SMALL_TABLE,
		(angle_x7 <= entry_x40) && (entry_x40 < angle_x7 + 14'd7),
		"angle does not match nearest entry")

endmodule

bind hall_pair_nearest_angle hpna_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_hpna_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
